>>> rtl/sax_series_encoder_defines.svh
// Assertion macros for the SAX series encoder checker
`ifndef SAX_SERIES_ENCODER_DEFINES_SVH
`define SAX_SERIES_ENCODER_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle
`define SAX_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence in the next cycle
`define SAX_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sax_pkg.sv
// Shared constants, types and breakpoint table for the SAX series encoder
`default_nettype none
package sax_pkg;

    localparam int SEGMENTS_DEF       = 14;
    localparam int SYMBOL_BITS        = 8;
    localparam int MAX_SEG_LEN_DEF    = 4095;
    localparam int QUEUE_DEPTH_DEF    = 4;
    localparam int SAMPLE_W           = 32;
    localparam int SEG_LEN_W          = 12;
    localparam int SCALE_W            = 25;
    localparam int SCALE_FRAC         = 24;
    localparam int SUM_W              = 44;
    localparam int IDX_W              = 4;
    localparam int BP_HALF            = 127;
    localparam int BP_COUNT           = 255;

    localparam logic [0:0] REG_SEG_LENGTH = 1'b0;
    localparam logic [0:0] REG_SEG_SCALE  = 1'b1;

    localparam logic [SEG_LEN_W-1:0] SEG_LEN_RESET = 12'd10;
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 25'd1677722;

    typedef struct packed {
        logic                    last;
        logic [IDX_W-1:0]        index;
        logic signed [SUM_W-1:0] sum;
    } t_seg_beat;

    // Positive breakpoints, units of 1e-8
    function automatic logic [27:0] bp_pos(input logic [6:0] i);
        logic [27:0] v;
        case (i)
            7'd0: v = 28'd979167;    7'd1: v = 28'd1958429;   7'd2: v = 28'd2937878;
            7'd3: v = 28'd3917609;   7'd4: v = 28'd4897716;   7'd5: v = 28'd5878294;
            7'd6: v = 28'd6859437;   7'd7: v = 28'd7841241;   7'd8: v = 28'd8823802;
            7'd9: v = 28'd9807215;   7'd10: v = 28'd10791578; 7'd11: v = 28'd11776987;
            7'd12: v = 28'd12763542; 7'd13: v = 28'd13751340; 7'd14: v = 28'd14740482;
            7'd15: v = 28'd15731068; 7'd16: v = 28'd16723201; 7'd17: v = 28'd17716982;
            7'd18: v = 28'd18712516; 7'd19: v = 28'd19709908; 7'd20: v = 28'd20709265;
            7'd21: v = 28'd21710695; 7'd22: v = 28'd22714306; 7'd23: v = 28'd23720211;
            7'd24: v = 28'd24728522; 7'd25: v = 28'd25739353; 7'd26: v = 28'd26752821;
            7'd27: v = 28'd27769044; 7'd28: v = 28'd28788143; 7'd29: v = 28'd29810241;
            7'd30: v = 28'd30835463; 7'd31: v = 28'd31863936; 7'd32: v = 28'd32895791;
            7'd33: v = 28'd33931161; 7'd34: v = 28'd34970180; 7'd35: v = 28'd36012989;
            7'd36: v = 28'd37059729; 7'd37: v = 28'd38110545; 7'd38: v = 28'd39165587;
            7'd39: v = 28'd40225007; 7'd40: v = 28'd41288960; 7'd41: v = 28'd42357608;
            7'd42: v = 28'd43431116; 7'd43: v = 28'd44509652; 7'd44: v = 28'd45593392;
            7'd45: v = 28'd46682512; 7'd46: v = 28'd47777199; 7'd47: v = 28'd48877641;
            7'd48: v = 28'd49984034; 7'd49: v = 28'd51096581; 7'd50: v = 28'd52215488;
            7'd51: v = 28'd53340971; 7'd52: v = 28'd54473251; 7'd53: v = 28'd55612559;
            7'd54: v = 28'd56759132; 7'd55: v = 28'd57913216; 7'd56: v = 28'd59075066;
            7'd57: v = 28'd60244945; 7'd58: v = 28'd61423129; 7'd59: v = 28'd62609901;
            7'd60: v = 28'd63805558; 7'd61: v = 28'd65010407; 7'd62: v = 28'd66224768;
            7'd63: v = 28'd67448975; 7'd64: v = 28'd68683375; 7'd65: v = 28'd69928330;
            7'd66: v = 28'd71184220; 7'd67: v = 28'd72451438; 7'd68: v = 28'd73730400;
            7'd69: v = 28'd75021538; 7'd70: v = 28'd76325304; 7'd71: v = 28'd77642176;
            7'd72: v = 28'd78972652; 7'd73: v = 28'd80317257; 7'd74: v = 28'd81676542;
            7'd75: v = 28'd83051088; 7'd76: v = 28'd84441508; 7'd77: v = 28'd85848447;
            7'd78: v = 28'd87272589; 7'd79: v = 28'd88714656; 7'd80: v = 28'd90175411;
            7'd81: v = 28'd91655667; 7'd82: v = 28'd93156283; 7'd83: v = 28'd94678176;
            7'd84: v = 28'd96222320; 7'd85: v = 28'd97789754; 7'd86: v = 28'd99381591;
            7'd87: v = 28'd100999017; 7'd88: v = 28'd102643306; 7'd89: v = 28'd104315826;
            7'd90: v = 28'd106018048; 7'd91: v = 28'd107751557; 7'd92: v = 28'd109518065;
            7'd93: v = 28'd111319428; 7'd94: v = 28'd113157656; 7'd95: v = 28'd115034938;
            7'd96: v = 28'd116953661; 7'd97: v = 28'd118916435; 7'd98: v = 28'd120926123;
            7'd99: v = 28'd122985876; 7'd100: v = 28'd125099172; 7'd101: v = 28'd127269864;
            7'd102: v = 28'd129502241; 7'd103: v = 28'd131801090; 7'd104: v = 28'd134171784;
            7'd105: v = 28'd136620382; 7'd106: v = 28'd139153749; 7'd107: v = 28'd141779714;
            7'd108: v = 28'd144507258; 7'd109: v = 28'd147346758; 7'd110: v = 28'd150310294;
            7'd111: v = 28'd153412054; 7'd112: v = 28'd156668859; 7'd113: v = 28'd160100866;
            7'd114: v = 28'd163732538; 7'd115: v = 28'd167593972; 7'd116: v = 28'd171722812;
            7'd117: v = 28'd176167041; 7'd118: v = 28'd180989224; 7'd119: v = 28'd186273187;
            7'd120: v = 28'd192135077; 7'd121: v = 28'd198742789; 7'd122: v = 28'd206352790;
            7'd123: v = 28'd215387469; 7'd124: v = 28'd226622681; 7'd125: v = 28'd241755902;
            7'd126: v = 28'd266006747;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

    // Signed breakpoint i of 0..254, units of 1e-8
    function automatic logic signed [28:0] breakpoint(input logic [7:0] i);
        logic signed [28:0] v;
        if (i < 8'(BP_HALF)) begin
            v = -$signed({1'b0, bp_pos(7'(8'(BP_HALF - 1) - i))});
        end else if (i == 8'(BP_HALF)) begin
            v = '0;
        end else begin
            v = $signed({1'b0, bp_pos(7'(i - 8'(BP_HALF + 1)))});
        end
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/sax_front.sv
// Front end: accumulates samples into segment sums and pushes closed segments
`default_nettype none
module sax_front #(
    parameter int SEGMENTS    = sax_pkg::SEGMENTS_DEF,
    parameter int MAX_SEG_LEN = sax_pkg::MAX_SEG_LEN_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [sax_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_last_sample,
    input  wire logic [sax_pkg::SEG_LEN_W-1:0]       i_seg_len,
    output logic                                     o_push,
    output sax_pkg::t_seg_beat                       o_beat,
    input  wire logic                                i_full
);
    localparam int CNT_W = sax_pkg::SEG_LEN_W;

    logic [CNT_W-1:0]                   r_run_count, n_run_count;
    logic [sax_pkg::IDX_W-1:0]          r_seg_count, n_seg_count;
    logic signed [sax_pkg::SUM_W-1:0]   r_run_sum, n_run_sum;
    logic [CNT_W-1:0]                   len;
    logic [CNT_W-1:0]                   cnt_inc;
    logic signed [sax_pkg::SUM_W-1:0]   sum_inc;
    logic                               accept, active, close;

    always_comb begin
        len = i_seg_len;
        if (len == '0) begin
            len = CNT_W'(1);
        end
        if (32'(len) > 32'(MAX_SEG_LEN)) begin
            len = CNT_W'(MAX_SEG_LEN);
        end
    end

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign active  = 32'(r_seg_count) < 32'(SEGMENTS);
    assign cnt_inc = r_run_count + CNT_W'(1);
    assign sum_inc = r_run_sum + sax_pkg::SUM_W'(i_sample);
    assign close   = accept && active && (cnt_inc >= len);

    assign o_push       = close;
    assign o_beat.sum   = sum_inc;
    assign o_beat.index = r_seg_count;
    assign o_beat.last  = 32'(r_seg_count) == 32'(SEGMENTS - 1);

    always_comb begin
        n_run_count = r_run_count;
        n_seg_count = r_seg_count;
        n_run_sum   = r_run_sum;
        if (accept) begin
            if (active) begin
                if (close) begin
                    n_run_count = '0;
                    n_run_sum   = '0;
                    n_seg_count = r_seg_count + sax_pkg::IDX_W'(1);
                end else begin
                    n_run_count = cnt_inc;
                    n_run_sum   = sum_inc;
                end
            end
            if (i_last_sample) begin
                n_run_count = '0;
                n_run_sum   = '0;
                n_seg_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count <= '0;
            r_seg_count <= '0;
            r_run_sum   <= '0;
        end else begin
            r_run_count <= n_run_count;
            r_seg_count <= n_seg_count;
            r_run_sum   <= n_run_sum;
        end
    end
endmodule
`default_nettype wire

>>> rtl/sax_fifo.sv
// Short queue of closed segments between front and back ends
`default_nettype none
module sax_fifo #(
    parameter int DEPTH = sax_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire sax_pkg::t_seg_beat i_beat,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output sax_pkg::t_seg_beat      o_beat
);
    localparam int PW = $clog2(DEPTH);

    sax_pkg::t_seg_beat r_mem [DEPTH];
    logic [PW-1:0]      r_wp, r_rp;
    logic [PW:0]        r_cnt;

    assign o_full  = r_cnt == (PW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_beat  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

>>> rtl/sax_back.sv
// Back end: scales a segment sum, then finds its symbol by binary search
`default_nettype none
module sax_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_pop,
    input  wire sax_pkg::t_seg_beat                i_beat,
    input  wire logic [sax_pkg::SCALE_W-1:0]       i_scale,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [sax_pkg::IDX_W-1:0]              o_segment_index,
    output logic [sax_pkg::SYMBOL_BITS-1:0]        o_symbol,
    output logic                                   o_last_symbol
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MHI  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SRCH = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam int PROD_W = sax_pkg::SUM_W + sax_pkg::SCALE_W + 1;
    localparam int LO_W   = 22;
    localparam int MP_W   = LO_W + sax_pkg::SCALE_W + 2;

    logic [2:0]                        r_state;
    sax_pkg::t_seg_beat                r_beat;
    logic signed [PROD_W-1:0]          r_prod;
    logic signed [63:0]                r_paa;
    logic [sax_pkg::SYMBOL_BITS-1:0]   r_sym;
    logic [3:0]                        r_step;
    logic signed [LO_W:0]              mul_a;
    logic signed [sax_pkg::SCALE_W:0]  mul_b;
    logic signed [MP_W-1:0]            mul_p;
    logic signed [PROD_W-1:0]          shifted;
    logic signed [31:0]                paa_sat;
    logic [sax_pkg::SYMBOL_BITS-1:0]   probe;
    logic signed [63:0]                bp_scaled;
    logic signed [63:0]                paa_scaled;

    // Low half of the sum on pop, signed high half in the cycle after
    always_comb begin
        if (r_state == ST_MHI) begin
            mul_a = $signed({r_beat.sum[sax_pkg::SUM_W-1], r_beat.sum[sax_pkg::SUM_W-1:LO_W]});
        end else begin
            mul_a = $signed({1'b0, i_beat.sum[LO_W-1:0]});
        end
    end
    assign mul_b = $signed({1'b0, i_scale});
    assign mul_p = mul_a * mul_b;

    assign shifted = r_prod >>> sax_pkg::SCALE_FRAC;
    always_comb begin
        if (shifted > PROD_W'(64'sd2147483647)) begin
            paa_sat = 32'sh7FFFFFFF;
        end else if (shifted < -PROD_W'(64'sd2147483648)) begin
            paa_sat = 32'sh80000000;
        end else begin
            paa_sat = 32'(shifted);
        end
    end

    // probe: candidate symbol r_sym | bit; counts when breakpoint(probe-1) <= paa
    assign probe      = r_sym | (8'd128 >> r_step);
    assign bp_scaled  = 64'(sax_pkg::breakpoint(probe - 8'd1)) * 64'sd65536;
    assign paa_scaled = r_paa;

    assign o_pop           = (r_state == ST_IDLE) && i_valid;
    assign o_valid         = r_state == ST_OUT;
    assign o_segment_index = r_beat.index;
    assign o_symbol        = r_sym;
    assign o_last_symbol   = r_beat.last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_beat <= i_beat;
            r_prod <= PROD_W'(mul_p);
        end
        if (r_state == ST_MHI) begin
            r_prod <= r_prod + (PROD_W'(mul_p) <<< LO_W);
        end
        if (r_state == ST_MUL) begin
            r_paa <= 64'(paa_sat) * 64'sd100000000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sym   <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= ST_MHI;
                    end
                end
                ST_MHI: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_sym   <= '0;
                    r_step  <= '0;
                    r_state <= ST_SRCH;
                end
                ST_SRCH: begin
                    if (bp_scaled <= paa_scaled) begin
                        r_sym <= probe;
                    end
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd7) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/sax_series_encoder.sv
// SAX series encoder top level: configuration registers, front end, queue, back end
// Samples are taken one per cycle while o_stall is low; a segment closes after
// segment_length samples and its 44-bit sum enters a four-entry queue. The back end
// scales each sum (the 44x26 product built from two 23x26 halves, low on pop, high
// in ST_MHI, then one scale-by-1e8 multiply in ST_MUL) and finds the symbol with an
// 8-step binary search over the breakpoint table; it pops no new sum until the
// symbol is accepted. Sustained rate is one sample per cycle while segment_length is
// 12 or more and output is unstalled; shorter segments throttle input via the queue.
`default_nettype none
module sax_series_encoder #(
    parameter int SEGMENTS    = sax_pkg::SEGMENTS_DEF,
    parameter int MAX_SEG_LEN = sax_pkg::MAX_SEG_LEN_DEF,
    parameter int QUEUE_DEPTH = sax_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [sax_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire logic                                  i_last_sample,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [sax_pkg::IDX_W-1:0]                  o_segment_index,
    output logic [sax_pkg::SYMBOL_BITS-1:0]            o_symbol,
    output logic                                       o_last_symbol,
    input  wire logic                                  i_cfg_we,
    input  wire logic [0:0]                            i_cfg_index,
    input  wire logic [sax_pkg::SCALE_W-1:0]           i_cfg_data
);
    logic [sax_pkg::SEG_LEN_W-1:0] r_seg_len;
    logic [sax_pkg::SCALE_W-1:0]   r_scale;
    logic                          push, full, q_valid, pop;
    sax_pkg::t_seg_beat            push_beat, q_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= sax_pkg::SEG_LEN_RESET;
            r_scale   <= sax_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sax_pkg::REG_SEG_LENGTH: r_seg_len <= i_cfg_data[sax_pkg::SEG_LEN_W-1:0];
                sax_pkg::REG_SEG_SCALE:  r_scale   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sax_front #(.SEGMENTS(SEGMENTS), .MAX_SEG_LEN(MAX_SEG_LEN)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_sample, .i_last_sample,
        .i_seg_len(r_seg_len), .o_push(push), .o_beat(push_beat), .i_full(full)
    );

    sax_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_beat(push_beat), .o_full(full),
        .i_pop(pop), .o_valid(q_valid), .o_beat(q_beat)
    );

    sax_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_pop(pop), .i_beat(q_beat),
        .i_scale(r_scale), .o_valid, .i_stall, .o_segment_index, .o_symbol,
        .o_last_symbol
    );
endmodule
`default_nettype wire

>>> rtl/sax_checker.sv
// Port-level checker for the SAX series encoder and its bind
`default_nettype none
`include "sax_series_encoder_defines.svh"
module sax_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [3:0] o_segment_index,
    input wire logic       o_last_symbol
);
    `SAX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "beat dropped")
    `SAX_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, o_valid && o_last_symbol,
        o_segment_index == 4'd13, "last symbol index")
    `SAX_ASSERT_IMPL(a_idx_rng, i_clk, i_rst_n, o_valid, o_segment_index <= 4'd13,
        "index range")
endmodule

bind sax_series_encoder sax_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_segment_index, .o_last_symbol
);
`default_nettype wire
